FILE: src/slrcc_pkg.sv
// ----------------------------------------------------------------------------
// slrcc_pkg: shared types and constants of the stereo consistency check
// Field widths, request and register codes, result classes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slrcc_pkg;

	// field widths
	localparam int COL_W   = 10;
	localparam int DISP_W  = 13;
	localparam int ENTRY_W = DISP_W + 1;
	localparam int THR_W   = 12;
	localparam int RW_W    = 11;
	localparam int CFG_W   = THR_W;

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_CHECK = 1'b1;

	// configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_ROW_WIDTH = 1'b1;

	// configuration reset values
	localparam logic [THR_W-1:0] THRESHOLD_RST = 12'd16;
	localparam logic [RW_W-1:0]  ROW_WIDTH_RST = 11'd1024;

	// pixel classification
	typedef enum logic [1:0] {
		CLASS_CONSISTENT = 2'd0,
		CLASS_OCCLUSION  = 2'd1,
		CLASS_MISMATCH   = 2'd2
	} pix_class_t;

	// controller to datapath
	typedef struct packed {
		logic       load_we;
		logic       chk_start;
		logic       fetch;
		logic       proj;
		logic       cmp;
		logic       rd_back;
		logic       inval;
		logic       res_we;
		logic       res_keep;
		pix_class_t res_class;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic col_in_row;
		logic le_valid;
		logic cr_ok;
		logic re_valid;
		logic within_thr;
		logic crl_ok;
		logic occl;
	} dp_stat_t;

endpackage

FILE: src/slrcc_dp.sv
// ----------------------------------------------------------------------------
// slrcc_dp: datapath of the stereo consistency check
// Holds the left and right row stores, the configuration registers, the
// shared projection adder and rounder, and the result registers.
// ----------------------------------------------------------------------------
module slrcc_dp #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  slrcc_pkg::dp_cmd_t                  cmd,
	output slrcc_pkg::dp_stat_t                 stat,
	input  logic [slrcc_pkg::COL_W-1:0]         column,
	input  logic signed [slrcc_pkg::DISP_W-1:0] left_disp,
	input  logic                                left_valid,
	input  logic signed [slrcc_pkg::DISP_W-1:0] right_disp,
	input  logic                                right_valid,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [slrcc_pkg::CFG_W-1:0]         cfg_data,
	output slrcc_pkg::pix_class_t               pixel_class,
	output logic signed [slrcc_pkg::DISP_W-1:0] out_disp,
	output logic                                out_valid
);
	import slrcc_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WW   = (AW + 1 > RW_W) ? AW + 1 : RW_W;
	localparam int PMAX = (AW + FRAC_BITS > DISP_W) ? AW + FRAC_BITS : DISP_W;
	localparam int VW   = PMAX + 2;
	localparam int HALF = (2 ** FRAC_BITS) / 2;

	// configuration registers
	logic [THR_W-1:0] threshold_q;
	logic [RW_W-1:0]  row_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			row_width_q <= ROW_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_ROW_WIDTH: row_width_q <= cfg_data[RW_W-1:0];
				default:       threshold_q <= threshold_q;
			endcase
		end
	end

	// effective row width, clamped to the store depth
	logic [WW-1:0] width_eff;
	logic          ld_in_range;

	always_comb begin
		width_eff = (WW'(row_width_q) < WW'(MAX_WIDTH)) ? WW'(row_width_q) : WW'(MAX_WIDTH);
	end

	assign ld_in_range = WW'(column) < WW'(MAX_WIDTH);

	// working registers
	logic [AW-1:0]            x_q;
	logic [AW-1:0]            cr_q;
	logic signed [DISP_W-1:0] d_q;
	logic [VW-1:0]            mag_q;
	logic                     neg_q;

	// row stores and their registered read data
	logic [ENTRY_W-1:0] left_mem  [MAX_WIDTH];
	logic [ENTRY_W-1:0] right_mem [MAX_WIDTH];
	logic [ENTRY_W-1:0] left_rd_q;
	logic [ENTRY_W-1:0] right_rd_q;

	// shared rounder: magnitude plus half, shifted down
	logic [VW-1:0] r;
	assign r = (mag_q + VW'(HALF)) >> FRAC_BITS;

	// store ports
	logic               left_we;
	logic [AW-1:0]      left_waddr;
	logic [ENTRY_W-1:0] left_wdata;
	logic [AW-1:0]      left_raddr;
	logic               right_we;

	always_comb begin
		left_we    = (cmd.load_we && ld_in_range) || cmd.inval;
		left_waddr = cmd.load_we ? AW'(column) : x_q;
		left_wdata = cmd.load_we ? {left_valid, left_disp} : '0;
		left_raddr = cmd.rd_back ? AW'(r) : AW'(column);
		right_we   = cmd.load_we && ld_in_range;
	end

	always_ff @(posedge clk) begin
		if (left_we) begin
			left_mem[left_waddr] <= left_wdata;
		end
		left_rd_q <= left_mem[left_raddr];
	end

	always_ff @(posedge clk) begin
		if (right_we) begin
			right_mem[AW'(column)] <= {right_valid, right_disp};
		end
		right_rd_q <= right_mem[AW'(r)];
	end

	// projection adder: column scaled up plus a disparity offset
	logic [AW-1:0]            pa;
	logic signed [DISP_W:0]   pb;
	logic signed [VW-1:0]     v;
	logic [VW-1:0]            v_mag;
	logic signed [DISP_W-1:0] le_disp;
	logic signed [DISP_W-1:0] dr;

	assign le_disp = $signed(left_rd_q[DISP_W-1:0]);
	assign dr      = $signed(right_rd_q[DISP_W-1:0]);

	always_comb begin
		pa    = cmd.cmp ? cr_q : x_q;
		pb    = cmd.cmp ? (DISP_W + 1)'(dr) : -((DISP_W + 1)'(le_disp));
		v     = $signed(VW'(pa) << FRAC_BITS) + VW'(pb);
		v_mag = v[VW-1] ? VW'(-v) : VW'(v);
	end

	always_ff @(posedge clk) begin
		if (cmd.chk_start) begin
			x_q <= AW'(column);
		end
		if (cmd.fetch) begin
			d_q <= le_disp;
		end
		if (cmd.fetch || cmd.cmp) begin
			mag_q <= v_mag;
			neg_q <= v[VW-1];
		end
		if (cmd.proj) begin
			cr_q <= AW'(r);
		end
	end

	// disparity difference against the threshold
	logic signed [DISP_W:0] diff;
	logic [DISP_W:0]        abs_diff;

	always_comb begin
		diff     = (DISP_W + 1)'(d_q) - (DISP_W + 1)'(dr);
		abs_diff = diff[DISP_W] ? (DISP_W + 1)'(-diff) : (DISP_W + 1)'(diff);
	end

	// status toward the controller
	always_comb begin
		stat.col_in_row = WW'(column) < width_eff;
		stat.le_valid   = left_rd_q[ENTRY_W-1];
		stat.cr_ok      = (!neg_q || (r == '0)) && (r < VW'(width_eff));
		stat.re_valid   = right_rd_q[ENTRY_W-1];
		stat.within_thr = abs_diff <= (DISP_W + 1)'(threshold_q);
		stat.crl_ok     = !neg_q && (r != '0) && (r < VW'(width_eff));
		stat.occl       = !left_rd_q[ENTRY_W-1] || (le_disp > d_q);
	end

	// result registers
	pix_class_t               pixel_class_q;
	logic signed [DISP_W-1:0] out_disp_q;
	logic                     out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			pixel_class_q <= cmd.res_class;
			out_valid_q   <= cmd.res_keep;
			out_disp_q    <= cmd.res_keep ? d_q : '0;
		end
	end

	assign pixel_class = pixel_class_q;
	assign out_disp    = out_disp_q;
	assign out_valid   = out_valid_q;

endmodule

FILE: src/slrcc_ctrl.sv
// ----------------------------------------------------------------------------
// slrcc_ctrl: sequencer of the stereo consistency check
// Walks one check item through fetch, projection, compare, back projection
// and classification; loads finish in the accept cycle.
// ----------------------------------------------------------------------------
module slrcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	input  slrcc_pkg::dp_stat_t stat,
	output slrcc_pkg::dp_cmd_t  cmd,
	output logic                busy,
	output logic                result_valid
);
	import slrcc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FETCH = 6'b000010,
		ST_PROJ  = 6'b000100,
		ST_CMP   = 6'b001000,
		ST_BACK  = 6'b010000,
		ST_CLASS = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_LOAD) begin
						cmd.load_we = 1'b1;
					end else if (stat.col_in_row) begin
						cmd.chk_start = 1'b1;
						state_d       = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				if (!stat.le_valid) begin
					cmd.res_we    = 1'b1;
					cmd.res_class = CLASS_MISMATCH;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_PROJ;
				end
			end
			ST_PROJ: begin
				cmd.proj = 1'b1;
				if (!stat.cr_ok) begin
					cmd.res_we    = 1'b1;
					cmd.res_class = CLASS_MISMATCH;
					cmd.inval     = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				if (!stat.re_valid) begin
					cmd.res_we    = 1'b1;
					cmd.res_class = CLASS_MISMATCH;
					cmd.inval     = 1'b1;
					state_d       = ST_IDLE;
				end else if (stat.within_thr) begin
					cmd.res_we    = 1'b1;
					cmd.res_keep  = 1'b1;
					cmd.res_class = CLASS_CONSISTENT;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_BACK;
				end
			end
			ST_BACK: begin
				cmd.rd_back = 1'b1;
				if (!stat.crl_ok) begin
					cmd.res_we    = 1'b1;
					cmd.res_class = CLASS_MISMATCH;
					cmd.inval     = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.res_we    = 1'b1;
				cmd.res_class = stat.occl ? CLASS_OCCLUSION : CLASS_MISMATCH;
				cmd.inval     = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= cmd.res_we;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

FILE: src/stereo_lr_consistency_check_unit.sv
// ----------------------------------------------------------------------------
// stereo_lr_consistency_check_unit: left-right disparity consistency check
// Row stores for left and right disparities with a per-pixel check that
// classifies each pixel as consistent, occluded or mismatched.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken when start is high and busy is low. A load item
// (req_type 0) writes one column of both row stores in the accept cycle,
// gives no result and keeps busy low, so loads go at one per cycle when idle.
// A check item (req_type 1) runs through the sequencer: each step waits on
// one registered read of a row store, and the reads depend on each other
// (left entry, right entry at the projection, left entry at the back
// projection). The result appears on pixel_class/out_disp/out_valid with
// result_valid high for exactly one cycle, registered from the step that
// decides it (invalid left pixel: fetch; projection outside row: projection;
// in-threshold or invalid right: compare; back projection outside row: back
// projection; else classification); busy falls in the strobe cycle, so the
// next item may be taken there. A check whose column lies beyond the row is
// taken and dropped. The receiver cannot stall; results are never held back.
// Configuration writes (cfg_valid, cfg_ready always high) must be made while
// idle; the block does not enforce it. Reset clears the sequencer and
// restores the register defaults; the row stores hold nothing until loaded.
// ----------------------------------------------------------------------------
module stereo_lr_consistency_check_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 req_type,
	input  logic [slrcc_pkg::COL_W-1:0]          column,
	input  logic signed [slrcc_pkg::DISP_W-1:0]  left_disp,
	input  logic                                 left_valid,
	input  logic signed [slrcc_pkg::DISP_W-1:0]  right_disp,
	input  logic                                 right_valid,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [slrcc_pkg::CFG_W-1:0]          cfg_data,
	output logic                                 result_valid,
	output logic [1:0]                           pixel_class,
	output logic signed [slrcc_pkg::DISP_W-1:0]  out_disp,
	output logic                                 out_valid
);
	import slrcc_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	pix_class_t pixel_class_w;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	// sequencer
	slrcc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// stores and arithmetic
	slrcc_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.column      (column),
		.left_disp   (left_disp),
		.left_valid  (left_valid),
		.right_disp  (right_disp),
		.right_valid (right_valid),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_class (pixel_class_w),
		.out_disp    (out_disp),
		.out_valid   (out_valid)
	);

	assign pixel_class = pixel_class_w;

`ifndef SYNTHESIS
	// no result in the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result strobe directly after accept");

	// a result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without work in progress");

	// a kept disparity is always a consistent pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_valid) |-> (pixel_class == CLASS_CONSISTENT))
		else $error("valid disparity on non-consistent pixel");

	// an invalidated pixel carries zero disparity
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !out_valid) |-> (out_disp == '0))
		else $error("invalid pixel with nonzero disparity");
`endif

endmodule

FILE: test/tb_stereo_lr_consistency_check_unit.sv
// ----------------------------------------------------------------------------
// tb_stereo_lr_consistency_check_unit: self-checking bench of the consistency check
// Loads and checks go into a queue that a clocked driver feeds to the unit with
// random idle bursts. Each accepted check is classified against shadow row
// stores, and a monitor compares every result strobe with the oldest
// expectation. Phases sweep the threshold and row width through their extremes.
// ----------------------------------------------------------------------------
module tb_stereo_lr_consistency_check_unit;
	import slrcc_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int FRAC        = 4;
	localparam int ONE         = 1 << FRAC;
	localparam int HALF        = ONE >> 1;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE      = 8;

	// one item as it goes to the unit
	typedef struct packed {
		logic                     kind;
		logic [COL_W-1:0]         col;
		logic signed [DISP_W-1:0] ld;
		logic                     lv;
		logic signed [DISP_W-1:0] rd;
		logic                     rv;
	} pix_req_t;

	// one row store entry
	typedef struct packed {
		logic                     ok;
		logic signed [DISP_W-1:0] disp;
	} disp_entry_t;

	// one classified pixel
	typedef struct packed {
		pix_class_t               cls;
		logic signed [DISP_W-1:0] disp;
		logic                     ok;
	} pix_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     req_type = REQ_LOAD;
	logic [COL_W-1:0]         column = '0;
	logic signed [DISP_W-1:0] left_disp = '0;
	logic                     left_valid = 1'b0;
	logic signed [DISP_W-1:0] right_disp = '0;
	logic                     right_valid = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic                     cfg_index = CFG_THRESHOLD;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     result_valid;
	logic [1:0]               pixel_class;
	logic signed [DISP_W-1:0] out_disp;
	logic                     out_valid;

	stereo_lr_consistency_check_unit #(
		.MAX_WIDTH(MAX_W),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.column(column),
		.left_disp(left_disp),
		.left_valid(left_valid),
		.right_disp(right_disp),
		.right_valid(right_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.pixel_class(pixel_class),
		.out_disp(out_disp),
		.out_valid(out_valid)
	);

	always #1 clk = ~clk;

	// shadow state of the unit
	disp_entry_t left_shadow [MAX_W];
	disp_entry_t right_shadow [MAX_W];
	logic [THR_W-1:0] thr_shadow = THRESHOLD_RST;
	logic [RW_W-1:0]  width_shadow = ROW_WIDTH_RST;

	pix_req_t    pending_reqs[$];
	pix_result_t expected_pixels[$];
	pix_req_t    drv_req;
	bit          loaded [MAX_W];
	int          n_sent = 0;
	int          n_acc = 0;
	int          errors = 0;
	int          gap_pct = 0;
	int          idle_left = 0;
	int          stall_cycles = 0;
	int          scene_base = 0;
	int          scene_span = 15;

	// Q-format value to column, half away from zero
	function automatic int round_col(input int v);
		if (v >= 0)
			return (v + HALF) >>> FRAC;
		return -((-v + HALF) >>> FRAC);
	endfunction

	// apply one accepted item to the shadow stores and queue its result
	function automatic void check_pixel(input pix_req_t r);
		int x, w, d, dr, cr, crl, diff;
		disp_entry_t le, re, ll;
		pix_result_t res;
		x = r.col;
		if (r.kind == REQ_LOAD) begin
			left_shadow[x]  = '{ok: r.lv, disp: r.ld};
			right_shadow[x] = '{ok: r.rv, disp: r.rd};
			return;
		end
		w = (width_shadow < MAX_W) ? width_shadow : MAX_W;
		if (x >= w)
			return;
		res = '{cls: CLASS_MISMATCH, disp: '0, ok: 1'b0};
		le = left_shadow[x];
		if (le.ok) begin
			d = $signed(le.disp);
			cr = round_col(x * ONE - d);
			if (cr < 0 || cr >= w) begin
				left_shadow[x] = '0;
			end else begin
				re = right_shadow[cr];
				if (!re.ok) begin
					left_shadow[x] = '0;
				end else begin
					dr = $signed(re.disp);
					diff = (d > dr) ? d - dr : dr - d;
					if (diff <= int'(thr_shadow)) begin
						res = '{cls: CLASS_CONSISTENT, disp: le.disp, ok: 1'b1};
					end else begin
						// back projection decides occlusion against mismatch
						crl = round_col(cr * ONE + dr);
						if (crl > 0 && crl < w) begin
							ll = left_shadow[crl];
							if (!ll.ok || $signed(ll.disp) > d)
								res.cls = CLASS_OCCLUSION;
						end
						left_shadow[x] = '0;
					end
				end
			end
		end
		expected_pixels.push_back(res);
	endfunction

	// driver: presents queued items, idles in random bursts after an accept
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				check_pixel(drv_req);
				n_acc++;
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (start && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
					idle_left = $urandom_range(1, 19) - 1;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					drv_req = pending_reqs.pop_front();
					req_type    <= drv_req.kind;
					column      <= drv_req.col;
					left_disp   <= drv_req.ld;
					left_valid  <= drv_req.lv;
					right_disp  <= drv_req.rd;
					right_valid <= drv_req.rv;
					start       <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobe must match the oldest expectation
	always @(posedge clk) begin
		pix_result_t e;
		if (arst_n && result_valid) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result class %0d disp %0d valid %0b", $time,
					pixel_class, out_disp, out_valid);
				errors++;
			end else begin
				e = expected_pixels.pop_front();
				if (pixel_class !== e.cls) begin
					$display("%0t: pixel_class expected %0d got %0d", $time, e.cls, pixel_class);
					errors++;
				end
				if (out_disp !== e.disp) begin
					$display("%0t: out_disp expected %0d got %0d", $time,
						$signed(e.disp), out_disp);
					errors++;
				end
				if (out_valid !== e.ok) begin
					$display("%0t: out_valid expected %0b got %0b", $time, e.ok, out_valid);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_load(input int col, input int ld, input bit lv, input int rd,
		input bit rv);
		pix_req_t r;
		r.kind = REQ_LOAD;
		r.col = COL_W'(col);
		r.ld = DISP_W'(ld);
		r.lv = lv;
		r.rd = DISP_W'(rd);
		r.rv = rv;
		loaded[r.col] = 1'b1;
		pending_reqs.push_back(r);
		n_sent++;
	endtask

	// disparity fields of a check are don't-care, so they carry noise
	task automatic push_check(input int col);
		pix_req_t r;
		r.kind = REQ_CHECK;
		r.col = COL_W'(col);
		r.ld = DISP_W'($urandom_range(0, 8191));
		r.lv = 1'($urandom_range(0, 1));
		r.rd = DISP_W'($urandom_range(0, 8191));
		r.rv = 1'($urandom_range(0, 1));
		pending_reqs.push_back(r);
		n_sent++;
	endtask

	// piecewise flat scene so projections mostly land on matching disparities
	task automatic push_scene_load(input int col);
		int ld, rd;
		if ($urandom_range(0, 7) == 0)
			scene_base = $urandom_range(0, scene_span);
		ld = scene_base + int'($urandom_range(0, 12)) - 6;
		rd = scene_base + int'($urandom_range(0, 12)) - 6;
		if ($urandom_range(0, 6) == 0)
			rd += int'($urandom_range(0, 80)) - 40;
		if ($urandom_range(0, 19) == 0)
			ld = $urandom_range(0, 8191);
		if ($urandom_range(0, 19) == 0)
			rd = $urandom_range(0, 8191);
		push_load(col, ld, $urandom_range(0, 11) != 0, rd, $urandom_range(0, 11) != 0);
	endtask

	// register write, only while the unit is idle
	task automatic write_reg(input logic idx, input int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_THRESHOLD)
			thr_shadow = value[THR_W-1:0];
		else
			width_shadow = value[RW_W-1:0];
	endtask

	// wait until every item is taken and every result is in, then let it settle
	task automatic wait_idle();
		while (n_acc != n_sent || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// one setting of the registers with a row fill and a mostly ascending sweep
	task automatic run_phase(input int thr, input int w, input int n_items, input int gpct);
		int w_eff, x, sel;
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ROW_WIDTH, w);
		gap_pct = gpct;
		w_eff = (w < MAX_W) ? w : MAX_W;
		scene_span = ((w_eff < 24) ? w_eff : 24) * ONE + ONE - 1;
		// every entry a check can reach must hold a loaded value
		for (int c = 0; c < w_eff; c++)
			if (!loaded[c])
				push_scene_load(c);
		x = 0;
		repeat (n_items) begin
			sel = $urandom_range(0, 99);
			if (sel < 65 && w_eff > 0) begin
				push_check(x);
				x += $urandom_range(1, 2);
				if (x >= w_eff)
					x = 0;
			end else if (sel < 85 && w_eff > 0) begin
				push_scene_load($urandom_range(0, w_eff - 1));
			end else if (sel < 93) begin
				push_check($urandom_range(0, MAX_W - 1));
			end else begin
				push_load($urandom_range(0, MAX_W - 1), $urandom_range(0, 8191),
					1'($urandom_range(0, 1)), $urandom_range(0, 8191),
					1'($urandom_range(0, 1)));
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed row of eight pixels, threshold 0.25
		write_reg(CFG_THRESHOLD, 4);
		write_reg(CFG_ROW_WIDTH, 8);
		push_load(0, -4096, 1, 4095, 1);
		push_load(1, 4095, 0, -4096, 1);
		push_load(2, 40, 1, 18, 1);
		push_load(3, 16, 1, 0, 0);
		push_load(4, 24, 1, 0, 1);
		push_load(5, -8, 1, 8, 1);
		push_load(6, 16, 1, -48, 1);
		push_load(7, 40, 1, -1, 1);
		push_load(MAX_W - 1, 0, 1, 0, 0);
		// projection far outside the row
		push_check(0);
		// invalid left pixel
		push_check(1);
		// half step rounds away from zero to a negative column
		push_check(2);
		// within threshold
		push_check(3);
		// invalid right pixel
		push_check(4);
		// left at the back projection exceeds the pixel: occlusion
		push_check(5);
		// back projection onto the checked pixel itself
		push_check(6);
		// back projection hits an invalidated left entry: occlusion
		push_check(7);
		// pixel invalidated earlier
		push_check(0);
		// checks beyond the row are dropped
		push_check(8);
		push_check(MAX_W - 1);
		wait_idle();

		// row wider than the store is clamped to the store depth
		write_reg(CFG_ROW_WIDTH, 2047);
		push_load(MAX_W - 2, -32, 1, 0, 1);
		push_load(MAX_W - 1, 0, 1, 32, 1);
		// projection just past the last column
		push_check(MAX_W - 2);
		// back projection two columns past the last column
		push_check(MAX_W - 1);
		wait_idle();

		// register extremes and typical settings
		run_phase(0, 64, 50, 15);
		run_phase(4095, 32, 30, 40);
		run_phase(2, 1, 12, 15);
		run_phase(8, 0, 12, 40);
		run_phase($urandom_range(0, 40), 96, 50, 15);
		run_phase($urandom_range(0, 40), 120, 50, 40);
		run_phase(3, 120, 50, 0);
		run_phase($urandom_range(0, 24), $urandom_range(2, 128), 50, 0);

		if (errors == 0 && expected_pixels.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
